// ===== rtl/sfosc_pkg.sv =====
package sfosc_pkg;

   localparam int CORDIC_STEPS_DEF   = 18;
   localparam int PROB_FRAC_BITS_DEF = 16;

   localparam int ENERGY_W   = 32;
   localparam int PROB_W     = 17;
   localparam int STATUS_W   = 2;
   localparam int MODE_W     = 3;
   localparam int MIX_W      = 17;
   localparam int MASS_W     = 24;
   localparam int BASE_W     = 24;
   localparam int SCALE_W    = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int PROD_W    = SCALE_W + MASS_W + BASE_W;
   localparam int PHASE_W   = 62;
   localparam int DIV_STEPS = PROD_W + 30;
   localparam int REM_W     = ENERGY_W + 1;
   localparam int XY_W      = 33;
   localparam int Z_W       = 34;

   localparam logic [PHASE_W-1:0] PI_Q60      = 62'h3243F6A8885A308D;
   localparam logic [PHASE_W-1:0] HALF_PI_Q60 = PI_Q60 >> 1;

   localparam logic [PROB_W-1:0]  ONE_Q16         = 17'd65536;
   localparam logic [SCALE_W-1:0] PHASE_SCALE_RST = 18'd83034;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_E   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_EE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_MUMU = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 3'd5;

   localparam logic [MODE_W-1:0] MODE_E_SURV  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_E_STER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MU_SURV = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MU_E    = 3'd3;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
   } sfosc_tag_type;

   function automatic logic [31:0] atan_q30(input int i);
      case (i)
         0:       atan_q30 = 32'd843314857;
         1:       atan_q30 = 32'd497837829;
         2:       atan_q30 = 32'd263043837;
         3:       atan_q30 = 32'd133525159;
         4:       atan_q30 = 32'd67021687;
         5:       atan_q30 = 32'd33543516;
         6:       atan_q30 = 32'd16775851;
         7:       atan_q30 = 32'd8388437;
         8:       atan_q30 = 32'd4194283;
         9:       atan_q30 = 32'd2097149;
         10:      atan_q30 = 32'd1048576;
         11:      atan_q30 = 32'd524288;
         12:      atan_q30 = 32'd262144;
         13:      atan_q30 = 32'd131072;
         14:      atan_q30 = 32'd65536;
         15:      atan_q30 = 32'd32768;
         16:      atan_q30 = 32'd16384;
         17:      atan_q30 = 32'd8192;
         18:      atan_q30 = 32'd4096;
         19:      atan_q30 = 32'd2048;
         20:      atan_q30 = 32'd1024;
         21:      atan_q30 = 32'd512;
         22:      atan_q30 = 32'd256;
         23:      atan_q30 = 32'd128;
         24:      atan_q30 = 32'd64;
         25:      atan_q30 = 32'd32;
         26:      atan_q30 = 32'd16;
         27:      atan_q30 = 32'd8;
         28:      atan_q30 = 32'd4;
         29:      atan_q30 = 32'd2;
         default: atan_q30 = 32'd1;
      endcase
   endfunction

endpackage

// ===== rtl/sterile_two_flavor_osc_prob_top.sv =====
// 3+1 sterile-neutrino oscillation probability, one energy per transaction and one
// result per transaction. A new energy is taken every clock while the result side keeps
// up. The pipeline holds the 96-stage phase divider, one stage per CORDIC iteration
// and one per bit of the sine-squared quotient. A stalled result register holds the
// whole pipeline. After reset and after each register write the request side stays
// not ready while the constant phase product is rebuilt. Status 1 marks an invalid
// mode, status 2 a zero energy; both return probability zero.
module sterile_two_flavor_osc_prob_top
   import sfosc_pkg::*;
#(
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
   parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] energy
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [16:0] probability, zero fill above
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int P      = PROB_FRAC_BITS;
   localparam int S_W    = P + 1;
   localparam int SQ_W   = 64;
   localparam int NUM_W  = SQ_W + 1 - 24;
   localparam int AB_W   = 2 * MIX_W;
   localparam int MUL_W  = AB_W + S_W;
   localparam int T_W    = MUL_W + 1;
   localparam int PSMS_W = SCALE_W + MASS_W;
   localparam int HALF_W = PSMS_W / 2;
   localparam int PART_W = PSMS_W - HALF_W + BASE_W;

   logic [MODE_W-1:0]  mode_ff;
   logic [MIX_W-1:0]   mix_ee_ff;
   logic [MIX_W-1:0]   mix_mumu_ff;
   logic [MASS_W-1:0]  mass_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [SCALE_W-1:0] scale_ff;

   logic [PSMS_W-1:0]  psms_ff;
   logic [PART_W-1:0]  plo_ff;
   logic [PART_W-1:0]  phi_ff;
   logic [PROD_W-1:0]  numer_ff;
   logic [AB_W-1:0]    ab_ff;
   logic [1:0]         hold_ff;

   logic               enable;
   sfosc_tag_type      tag_entry;
   sfosc_tag_type      div_tag;
   logic [PHASE_W-1:0] div_phase;
   sfosc_tag_type      cor_tag;
   logic signed [XY_W-1:0]   cor_x;
   logic signed [XY_W-1:0]   cor_y;
   logic signed [2*XY_W-1:0] xsq;
   logic signed [2*XY_W-1:0] ysq;

   sfosc_tag_type     sq_tag_ff;
   logic [SQ_W-1:0]   xx_ff;
   logic [SQ_W-1:0]   yy_ff;
   sfosc_tag_type     den_tag_ff;
   logic [NUM_W-1:0]  yys_ff;
   logic [NUM_W-1:0]  dd_ff;
   logic [SQ_W:0]     sq_sum;

   sfosc_tag_type     qt_ff  [S_W];
   logic [S_W-1:0]    qq_ff  [S_W];
   logic [NUM_W-1:0]  qr_ff  [S_W];
   logic [NUM_W-1:0]  qd_ff  [S_W];

   sfosc_tag_type     mul_tag_ff;
   logic [MUL_W-1:0]  prod_ff;
   logic [S_W-1:0]    s_val;
   logic [AB_W-1:0]   mul_sel;

   logic [T_W-1:0]    t_sum;
   logic [T_W-1:0]    t_val;
   logic [T_W-1:0]    p_val;
   logic              rsp_valid_ff;
   logic [PROB_W-1:0] prob_ff;
   logic [PROB_W-1:0] prob_in;
   logic [STATUS_W-1:0] status_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_E_SURV;
         mix_ee_ff   <= '0;
         mix_mumu_ff <= '0;
         mass_ff     <= '0;
         base_ff     <= '0;
         scale_ff    <= PHASE_SCALE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff     <= csr_data[MODE_W-1:0];
            CSR_MIX_EE:   mix_ee_ff   <= csr_data[MIX_W-1:0];
            CSR_MIX_MUMU: mix_mumu_ff <= csr_data[MIX_W-1:0];
            CSR_MASS:     mass_ff     <= csr_data[MASS_W-1:0];
            CSR_BASE:     base_ff     <= csr_data[BASE_W-1:0];
            CSR_SCALE:    scale_ff    <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         hold_ff <= 2'd3;
      end else if (hold_ff != 2'd0) begin
         hold_ff <= hold_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      psms_ff  <= scale_ff * mass_ff;
      ab_ff    <= mix_ee_ff * mix_mumu_ff;
      plo_ff   <= PART_W'(psms_ff[HALF_W-1:0] * base_ff);
      phi_ff   <= psms_ff[PSMS_W-1:HALF_W] * base_ff;
      numer_ff <= PROD_W'(plo_ff) + (PROD_W'(phi_ff) << HALF_W);
   end

   // pipeline control
   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable && (hold_ff == 2'd0);

   always_comb begin
      tag_entry.valid = req_tvalid && (hold_ff == 2'd0);
      if (mode_ff > MODE_MU_E) begin
         tag_entry.status = ST_BAD_MODE;
      end else if (req_tdata == '0) begin
         tag_entry.status = ST_ZERO_E;
      end else begin
         tag_entry.status = ST_OK;
      end
   end

   sfosc_phase_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .tag_in    (tag_entry),
      .energy_in (req_tdata),
      .numer     (numer_ff),
      .tag_out   (div_tag),
      .phase_out (div_phase)
   );

   sfosc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .tag_in   (div_tag),
      .phase_in (div_phase),
      .tag_out  (cor_tag),
      .x_out    (cor_x),
      .y_out    (cor_y)
   );

   // squares
   assign xsq = cor_x * cor_x;
   assign ysq = cor_y * cor_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tag_ff  <= '0;
         den_tag_ff <= '0;
      end else if (enable) begin
         sq_tag_ff  <= cor_tag;
         den_tag_ff <= sq_tag_ff;
      end
   end

   assign sq_sum = {1'b0, xx_ff} + {1'b0, yy_ff};

   always_ff @(posedge clock) begin
      if (enable) begin
         xx_ff  <= xsq[SQ_W-1:0];
         yy_ff  <= ysq[SQ_W-1:0];
         yys_ff <= NUM_W'(yy_ff >> 24);
         dd_ff  <= sq_sum[SQ_W:24];
      end
   end

   // sine squared quotient, one bit per stage
   for (genvar k = 0; k < S_W; k++) begin : g_quo
      sfosc_tag_type    tag_prev;
      logic [S_W-1:0]   q_prev;
      logic [NUM_W-1:0] r_prev;
      logic [NUM_W-1:0] d_prev;
      logic [NUM_W:0]   sh;
      logic             ge;
      logic [NUM_W:0]   sub;

      if (k == 0) begin : g_first
         assign tag_prev = den_tag_ff;
         assign q_prev   = '0;
         assign d_prev   = dd_ff;
         assign r_prev   = yys_ff;
         assign sh       = {1'b0, r_prev};
      end else begin : g_next
         assign tag_prev = qt_ff[k-1];
         assign q_prev   = qq_ff[k-1];
         assign d_prev   = qd_ff[k-1];
         assign r_prev   = qr_ff[k-1];
         assign sh       = {r_prev, 1'b0};
      end

      assign ge  = sh >= {1'b0, d_prev};
      assign sub = sh - {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            qt_ff[k] <= '0;
         end else if (enable) begin
            qt_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            qq_ff[k] <= {q_prev[S_W-2:0], ge};
            qr_ff[k] <= ge ? sub[NUM_W-1:0] : sh[NUM_W-1:0];
            qd_ff[k] <= d_prev;
         end
      end
   end

   // mixing product
   assign s_val = (qd_ff[S_W-1] == '0) ? '0 : qq_ff[S_W-1];

   always_comb begin
      case (mode_ff)
         MODE_MU_E:    mul_sel = ab_ff;
         MODE_MU_SURV: mul_sel = AB_W'(mix_mumu_ff);
         default:      mul_sel = AB_W'(mix_ee_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_tag_ff <= '0;
      end else if (enable) begin
         mul_tag_ff <= qt_ff[S_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= mul_sel * s_val;
      end
   end

   // round, saturate, and take one minus the product in the survival modes
   always_comb begin
      if (mode_ff == MODE_MU_E) begin
         t_sum = {1'b0, prod_ff} + (T_W'(1) << (P + 17));
         t_val = t_sum >> (P + 18);
      end else begin
         t_sum = {1'b0, prod_ff} + (T_W'(1) << (P - 1));
         t_val = t_sum >> P;
      end
      case (mode_ff) inside
         MODE_E_SURV, MODE_MU_SURV:
            p_val = (t_val >= T_W'(ONE_Q16)) ? '0 : T_W'(ONE_Q16) - t_val;
         default:
            p_val = (t_val > T_W'(ONE_Q16)) ? T_W'(ONE_Q16) : t_val;
      endcase
      prob_in = (mul_tag_ff.status == ST_OK) ? p_val[PROB_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= mul_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prob_ff   <= prob_in;
         status_ff <= mul_tag_ff.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, prob_ff};
   assign rsp_tuser  = status_ff;

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> prob_ff == '0)
      else $error("nonzero probability with failure status");

   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> prob_ff <= ONE_Q16)
      else $error("probability above one");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_BAD_MODE || rsp_tuser == ST_ZERO_E)
      else $error("undefined status");

   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> !req_tready)
      else $error("request taken before phase product settled");

   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && mode_ff > MODE_MU_E |-> tag_entry.status == ST_BAD_MODE)
      else $error("invalid mode not flagged");
`endif

endmodule

// ===== rtl/sfosc_phase_div.sv =====
module sfosc_phase_div
   import sfosc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sfosc_tag_type       tag_in,
   input  logic [ENERGY_W-1:0] energy_in,
   input  logic [PROD_W-1:0]   numer,
   output sfosc_tag_type       tag_out,
   output logic [PHASE_W-1:0]  phase_out
);

   sfosc_tag_type       tag_ff [DIV_STEPS];
   logic [ENERGY_W-1:0] e_ff   [DIV_STEPS];
   logic [REM_W-1:0]    rem_ff [DIV_STEPS];
   logic [PHASE_W-1:0]  q_ff   [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int J = DIV_STEPS - 1 - k - 30;
      sfosc_tag_type       tag_prev;
      logic [ENERGY_W-1:0] e_prev;
      logic [REM_W-1:0]    rem_prev;
      logic [PHASE_W-1:0]  q_prev;
      logic                num_bit;
      logic [REM_W-1:0]    shifted;
      logic                ge;
      logic [REM_W-1:0]    rem_in;
      logic [PHASE_W:0]    qs;
      logic [PHASE_W:0]    qd;
      logic [PHASE_W-1:0]  q_in;

      if (k == 0) begin : g_first
         assign tag_prev = tag_in;
         assign e_prev   = energy_in;
         assign rem_prev = '0;
         assign q_prev   = '0;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign e_prev   = e_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      if (J >= 0) begin : g_bit
         assign num_bit = numer[J];
      end else begin : g_zero
         assign num_bit = 1'b0;
      end

      always_comb begin
         shifted = {rem_prev[REM_W-2:0], num_bit};
         ge      = shifted >= {1'b0, e_prev};
         rem_in  = ge ? shifted - {1'b0, e_prev} : shifted;
         qs      = {q_prev, ge};
         qd      = qs - {1'b0, PI_Q60};
         q_in    = (qs >= {1'b0, PI_Q60}) ? qd[PHASE_W-1:0] : qs[PHASE_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (enable) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            e_ff[k]   <= e_prev;
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign tag_out   = tag_ff[DIV_STEPS-1];
   assign phase_out = q_ff[DIV_STEPS-1];

endmodule

// ===== rtl/sfosc_cordic.sv =====
module sfosc_cordic
   import sfosc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  sfosc_tag_type           tag_in,
   input  logic [PHASE_W-1:0]      phase_in,
   output sfosc_tag_type           tag_out,
   output logic signed [XY_W-1:0]  x_out,
   output logic signed [XY_W-1:0]  y_out
);

   sfosc_tag_type          tag0_ff;
   logic signed [Z_W-1:0]  z0_ff;
   logic [PHASE_W-1:0]     folded;

   sfosc_tag_type          tag_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0] x_ff   [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff   [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff   [CORDIC_STEPS];

   assign folded = (phase_in > HALF_PI_Q60) ? PI_Q60 - phase_in : phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (enable) begin
         tag0_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z0_ff <= signed'({2'b00, folded[PHASE_W-1:30]});
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      sfosc_tag_type          tag_prev;
      logic signed [XY_W-1:0] x_prev;
      logic signed [XY_W-1:0] y_prev;
      logic signed [Z_W-1:0]  z_prev;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  ang;
      logic                   pos;

      if (k == 0) begin : g_first
         assign tag_prev = tag0_ff;
         assign x_prev   = signed'(XY_W'(1) << 30);
         assign y_prev   = '0;
         assign z_prev   = z0_ff;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign x_prev   = x_ff[k-1];
         assign y_prev   = y_ff[k-1];
         assign z_prev   = z_ff[k-1];
      end

      assign dx  = y_prev >>> k;
      assign dy  = x_prev >>> k;
      assign ang = signed'({2'b00, atan_q30(k)});
      assign pos = !z_prev[Z_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (enable) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k] <= pos ? x_prev - dx : x_prev + dx;
            y_ff[k] <= pos ? y_prev + dy : y_prev - dy;
            z_ff[k] <= pos ? z_prev - ang : z_prev + ang;
         end
      end
   end

   assign tag_out = tag_ff[CORDIC_STEPS-1];
   assign x_out   = x_ff[CORDIC_STEPS-1];
   assign y_out   = y_ff[CORDIC_STEPS-1];

endmodule

// ===== verif/tb_sterile_two_flavor_osc_prob_top.sv =====
`timescale 1ns / 100ps

module tb_sterile_two_flavor_osc_prob_top
   import sfosc_pkg::*;
;

   class osc_scoreboard;
      typedef struct {
         logic [PROB_W-1:0]   prob;
         logic [STATUS_W-1:0] status;
      } osc_result_type;

      osc_result_type    expected_q[$];
      int                errors;
      logic [MODE_W-1:0] mode;
      logic [MIX_W-1:0]  mix_ee;
      logic [MIX_W-1:0]  mix_mumu;
      logic [MASS_W-1:0] mass_split;
      logic [BASE_W-1:0] baseline;
      logic [SCALE_W-1:0] phase_scale;

      function new();
         errors      = 0;
         mode        = MODE_E_SURV;
         mix_ee      = '0;
         mix_mumu    = '0;
         mass_split  = '0;
         baseline    = '0;
         phase_scale = PHASE_SCALE_RST;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MODE:     mode        = val[MODE_W-1:0];
            CSR_MIX_EE:   mix_ee      = val[MIX_W-1:0];
            CSR_MIX_MUMU: mix_mumu    = val[MIX_W-1:0];
            CSR_MASS:     mass_split  = val[MASS_W-1:0];
            CSR_BASE:     baseline    = val[BASE_W-1:0];
            CSR_SCALE:    phase_scale = val[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] phase_mod_pi(bit [31:0] e);
         bit [127:0] num;
         bit [63:0]  rem;
         bit [63:0]  q;
         num = (128'(phase_scale) * 128'(mass_split) * 128'(baseline)) << 30;
         rem = 0;
         q   = 0;
         for (int i = 95; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            q   = q << 1;
            if (rem >= 64'(e)) begin
               rem  = rem - 64'(e);
               q[0] = 1'b1;
            end
            if (q >= 64'(PI_Q60))
               q = q - 64'(PI_Q60);
         end
         return q;
      endfunction

      function bit [63:0] sine_sq(bit [31:0] e);
         longint    atan_tab [18] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                                      524288, 262144, 131072, 65536, 32768, 16384, 8192};
         bit [63:0] r;
         longint    x;
         longint    y;
         longint    z;
         longint    dx;
         longint    dy;
         bit [63:0] xx;
         bit [63:0] yy;
         bit [63:0] dd;
         r = phase_mod_pi(e);
         if (r > (64'(PI_Q60) >> 1))
            r = 64'(PI_Q60) - r;
         z = longint'(r >> 30);
         x = longint'(1) << 30;
         y = 0;
         for (int i = 0; i < 18; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - atan_tab[i];
            end else begin
               x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
         end
         xx = x * x;
         yy = y * y;
         dd = (xx + yy) >> 24;
         yy = yy >> 24;
         if (dd == 0)
            return 0;
         return (yy << 16) / dd;
      endfunction

      function void note_energy(bit [31:0] e);
         osc_result_type res;
         bit [63:0]      s;
         bit [63:0]      t;
         res.prob   = '0;
         res.status = ST_OK;
         if (mode > MODE_MU_E) begin
            res.status = ST_BAD_MODE;
         end else if (e == 0) begin
            res.status = ST_ZERO_E;
         end else begin
            s = sine_sq(e);
            case (mode) inside
               MODE_E_SURV, MODE_MU_SURV: begin
                  t = ((mode == MODE_E_SURV ? 64'(mix_ee) : 64'(mix_mumu)) * s + 64'd32768) >> 16;
                  res.prob = t >= 65536 ? '0 : PROB_W'(65536 - t);
               end
               MODE_E_STER: begin
                  t = (64'(mix_ee) * s + 64'd32768) >> 16;
                  res.prob = t > 65536 ? ONE_Q16 : PROB_W'(t);
               end
               default: begin
                  t = (64'(mix_ee) * 64'(mix_mumu) * s + (64'd1 << 33)) >> 34;
                  res.prob = t > 65536 ? ONE_Q16 : PROB_W'(t);
               end
            endcase
         end
         expected_q.insert(expected_q.size(), res);
      endfunction

      task report(string what, longint got, longint want);
         $display("%0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check(logic [PROB_W-1:0] prob, logic [STATUS_W-1:0] status);
         osc_result_type want;
         if (expected_q.size() == 0) begin
            report("unexpected transaction, prob", prob, -1);
         end else begin
            want = expected_q.pop_front();
            if (prob !== want.prob)
               report("probability", prob, want.prob);
            if (status !== want.status)
               report("status", status, want.status);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   osc_scoreboard board = new();
   bit  gaps_on = 1'b1;
   int  stall_left = 0;

   sterile_two_flavor_osc_prob_top dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check(rsp_tdata[PROB_W-1:0], rsp_tuser);
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task configure(logic [2:0] m, logic [16:0] a, logic [16:0] b, logic [23:0] ms,
                  logic [23:0] bl, logic [17:0] ps);
      csr_write(CSR_MODE, 24'(m));
      csr_write(CSR_MIX_EE, 24'(a));
      csr_write(CSR_MIX_MUMU, 24'(b));
      csr_write(CSR_MASS, ms);
      csr_write(CSR_BASE, bl);
      csr_write(CSR_SCALE, 24'(ps));
   endtask

   task send_energy(logic [31:0] e);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= e;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_energy(e);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0)
         @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   function logic [31:0] pick_energy();
      case ($urandom_range(0, 9)) inside
         0:       return 32'd0;
         1, 2, 3: return $urandom();
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   function logic [16:0] pick_mix();
      case ($urandom_range(0, 5))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(MODE_E_SURV, 17'd52428, 17'd39321, 24'h100000, 24'd1024, 18'd83034);
      for (int m = 0; m < 4; m++) begin
         if (m != 0) begin
            drain();
            csr_write(CSR_MODE, 24'(m));
         end
         send_energy(32'd0);
         send_energy(32'd1);
         send_energy(32'hFFFF_FFFF);
         send_energy(32'h0001_0000);
         send_energy(32'h0000_0400);
      end
      drain();
      configure(3'd7, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF);
      send_energy(32'd0);
      send_energy(32'd12345);
      drain();
      csr_write(CSR_MODE, 24'(MODE_MU_E));
      send_energy(32'd1);
      send_energy(32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 11; ph++) begin
         if (ph == 10)
            gaps_on = 1'b0;
         if (ph == 0)
            configure(MODE_E_STER, 17'h1FFFF, 17'd0, 24'd0, 24'hFFFFFF, 18'd83034);
         else if (ph == 1)
            configure(MODE_E_SURV, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 24'd1, 18'd0);
         else
            configure(($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7))
                                                   : 3'($urandom_range(0, 3)),
                      pick_mix(), pick_mix(), 24'($urandom() >> $urandom_range(0, 8)),
                      24'($urandom() >> $urandom_range(8, 16)),
                      18'($urandom_range(0, 262143)));
         for (int k = 0; k < 112; k++) begin
            send_energy(pick_energy());
            if (ph == 4 && k == 50) begin
               drain();
            end
         end
         drain();
      end

      if (board.errors == 0)
         $display("sterile_two_flavor_osc_prob_top: match");
      else
         $display("sterile_two_flavor_osc_prob_top: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("sterile_two_flavor_osc_prob_top: mismatch");
      $finish;
   end
endmodule
